// ----- src/spq_pkg.sv -----
package spq_pkg;

  // Number of entries held by the queue; the cell chain is this long.
  localparam int unsigned DEPTH  = 16;
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned DATA_W = 32;
  localparam int unsigned OCC_W  = 5;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_DELETE = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_OVERFLOW  = 2'd1,
    STATUS_UNDERFLOW = 2'd2
  } status_e;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic [DATA_W-1:0] prio;
  } entry_t;

  typedef struct packed {
    logic insert;
    logic remove;
  } cell_ctrl_t;

endpackage

// ----- src/spq_if.sv -----
interface spq_req_if import spq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  opcode_e                  opcode;
  logic signed [DATA_W-1:0] item_value;
  logic signed [DATA_W-1:0] item_priority;

  modport source (output valid, opcode, item_value, item_priority, input ready);
  modport sink   (input valid, opcode, item_value, item_priority, output ready);
endinterface

interface spq_rsp_if import spq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  status_e                  status;
  logic signed [DATA_W-1:0] removed_value;
  logic signed [DATA_W-1:0] removed_priority;
  logic [OCC_W-1:0]         occupancy;

  modport source (output valid, status, removed_value, removed_priority, occupancy,
                  input ready);
  modport sink   (input valid, status, removed_value, removed_priority, occupancy,
                  output ready);
endinterface

// ----- src/spq_cell.sv -----
module spq_cell import spq_pkg::*; (
  input  logic       clk_i,
  input  cell_ctrl_t ctrl_i,
  input  logic       occupied_i,
  input  entry_t     new_i,
  input  entry_t     left_i,
  input  logic       left_stay_i,
  input  entry_t     right_i,
  output logic       stay_o,
  output entry_t     entry_o
);

  entry_t entry_q, entry_d;

  // Stay put when this entry is served no later than the new one.
  assign stay_o = occupied_i && ($signed(entry_q.prio) <= $signed(new_i.prio));

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.insert) begin
      if (stay_o) begin
        entry_d = entry_q;
      end else if (left_stay_i) begin
        entry_d = new_i;
      end else begin
        entry_d = left_i;
      end
    end else if (ctrl_i.remove) begin
      entry_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

// ----- src/sorted_priority_queue_top.sv -----
// Sorted priority queue of DEPTH entries (value, signed priority).
// Request channel req_i: opcode insert or delete, with item_value and
// item_priority used on insert. Response channel rsp_o: one response per
// request with status (ok, overflow, underflow), the removed entry on a
// successful delete (zero otherwise) and the occupancy after the request.
// Entries are held in a chain of cells in ascending priority order, the head
// in cell 0. On insert every cell compares its priority with the new one at
// once and either holds, takes the new entry or takes its left neighbor; on
// delete every cell takes its right neighbor. Ties leave in arrival order.
// The response is valid in the cycle after the request is accepted.
// Throughput: one request per cycle while responses are taken, set by the
// cell update and the one-entry response register.
// When the receiver stalls, the response register holds its result and
// req_i.ready drops until it is taken.
// Reset clears the entry count and the response valid; the queue is empty
// and ready at once, with no clearing pass.
module sorted_priority_queue_top import spq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  spq_req_if.sink   req_i,
  spq_rsp_if.source rsp_o
);

  logic [CNT_W-1:0] count_q, count_d;
  logic             rsp_valid_q;
  status_e          status_q, status_d;
  logic [DATA_W-1:0] rv_q, rv_d, rp_q, rp_d;
  logic [OCC_W-1:0] occ_q;

  logic       accept;
  logic       full, empty;
  cell_ctrl_t ctrl;
  entry_t     new_entry;

  entry_t     cell_entry [DEPTH];
  logic       cell_stay  [DEPTH];

  // Take a new request whenever the response slot is free or being drained.
  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;

  assign full  = (count_q == CNT_W'(DEPTH));
  assign empty = (count_q == '0);

  assign ctrl.insert = accept && (req_i.opcode == OP_INSERT) && !full;
  assign ctrl.remove = accept && (req_i.opcode == OP_DELETE) && !empty;

  assign new_entry.value = req_i.item_value;
  assign new_entry.prio  = req_i.item_priority;

  // Cell chain: left neighbor feeds inserts, right neighbor feeds deletes.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t left_entry, right_entry;
    logic   left_stay;
    logic   occupied;

    assign occupied = (CNT_W'(i) < count_q);

    if (i == 0) begin : g_head
      assign left_entry = new_entry;
      assign left_stay  = 1'b1;
    end else begin : g_body
      assign left_entry = cell_entry[i-1];
      assign left_stay  = cell_stay[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_entry = cell_entry[i];
    end else begin : g_inner
      assign right_entry = cell_entry[i+1];
    end

    spq_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .occupied_i  (occupied),
      .new_i       (new_entry),
      .left_i      (left_entry),
      .left_stay_i (left_stay),
      .right_i     (right_entry),
      .stay_o      (cell_stay[i]),
      .entry_o     (cell_entry[i])
    );
  end

  // Entry count and response payload.
  always_comb begin
    count_d  = count_q;
    status_d = STATUS_OK;
    rv_d     = '0;
    rp_d     = '0;
    if (accept) begin
      case (req_i.opcode)
        OP_INSERT: begin
          if (full) begin
            status_d = STATUS_OVERFLOW;
          end else begin
            count_d = count_q + CNT_W'(1);
          end
        end
        OP_DELETE: begin
          if (empty) begin
            status_d = STATUS_UNDERFLOW;
          end else begin
            rv_d    = cell_entry[0].value;
            rp_d    = cell_entry[0].prio;
            count_d = count_q - CNT_W'(1);
          end
        end
        default: begin
          status_d = STATUS_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // Load the response only with a new request; hold it while stalled.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      rv_q     <= rv_d;
      rp_q     <= rp_d;
      occ_q    <= OCC_W'(count_d);
    end
  end

  assign rsp_o.valid            = rsp_valid_q;
  assign rsp_o.status           = status_q;
  assign rsp_o.removed_value    = rv_q;
  assign rsp_o.removed_priority = rp_q;
  assign rsp_o.occupancy        = occ_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("entry count exceeds depth");

  a_insert_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.insert |=> count_q == $past(count_q) + CNT_W'(1))
    else $error("insert did not grow the queue by one");

  a_delete_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.remove |=> (rp_q == $past(cell_entry[0].prio)) &&
                    (rv_q == $past(cell_entry[0].value)))
    else $error("delete did not return the head entry");

  a_underflow_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q && (status_q == STATUS_UNDERFLOW) |-> (rv_q == '0) && (occ_q == '0))
    else $error("underflow response carries data");

  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q && !rsp_o.ready |-> !req_i.ready)
    else $error("request taken while response stalled");
`endif

endmodule
